[src/uacf_pkg.sv]
package uacf_pkg;

	localparam int CP_W   = 21;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef logic [CP_W-1:0] cp_t;

	localparam cp_t CP_REPL     = 21'h00FFFD;
	localparam cp_t CP_SHARP_S  = 21'h0000DF;
	localparam cp_t CP_LOWER_S  = 21'h000073;
	localparam cp_t CP_UPPER_A  = 21'h000041;
	localparam cp_t CP_UPPER_Z  = 21'h00005A;
	localparam cp_t CP_COMB_LO  = 21'h000300;
	localparam cp_t CP_COMB_HI  = 21'h00036F;
	localparam cp_t CP_LATX_LO  = 21'h000100;
	localparam cp_t CP_LATX_HI  = 21'h00024F;
	localparam cp_t CP_CYR_LO   = 21'h000410;
	localparam cp_t CP_CYR_HI   = 21'h00042F;
	localparam cp_t CP_CYR_IO   = 21'h000401;
	localparam cp_t CP_CYR_IO_L = 21'h000451;
	localparam cp_t CP_SIGMA_U  = 21'h0003A3;
	localparam cp_t CP_SIGMA_F  = 21'h0003C2;
	localparam cp_t CP_SIGMA_L  = 21'h0003C3;
	localparam cp_t CP_GRK_LO   = 21'h000391;
	localparam cp_t CP_GRK_MID1 = 21'h0003A1;
	localparam cp_t CP_GRK_MID2 = 21'h0003A4;
	localparam cp_t CP_GRK_HI   = 21'h0003AB;
	localparam cp_t CASE_OFS    = 21'd32;

	typedef enum logic [1:0] {
		FK_DROP,
		FK_ONE,
		FK_TWICE
	} fold_kind_t;

	typedef struct packed {
		cp_t        cp;
		fold_kind_t kind;
	} fold_t;

	typedef struct packed {
		cp_t [2:0]  cps;
		logic [1:0] cnt;
	} job_t;

	typedef struct packed {
		logic seq_open;
	} front_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

	function automatic logic [1:0] lead_need(logic [7:0] c);
		if (c[7:5] == 3'b110) return 2'd1;
		if (c[7:4] == 4'b1110) return 2'd2;
		if (c[7:3] == 5'b11110) return 2'd3;
		return 2'd0;
	endfunction

	function automatic cp_t single_cp(logic [7:0] c);
		return c[7] ? CP_REPL : {13'd0, c};
	endfunction

	function automatic cp_t strip_accent(cp_t cp);
		if (cp >= 21'hC0 && cp <= 21'hC5) return 21'h41;
		if (cp == 21'hC7) return 21'h43;
		if (cp >= 21'hC8 && cp <= 21'hCB) return 21'h45;
		if (cp >= 21'hCC && cp <= 21'hCF) return 21'h49;
		if (cp == 21'hD1) return 21'h4E;
		if (cp >= 21'hD2 && cp <= 21'hD6) return 21'h4F;
		if (cp >= 21'hD9 && cp <= 21'hDC) return 21'h55;
		if (cp >= 21'hE0 && cp <= 21'hE5) return 21'h61;
		if (cp == 21'hE7) return 21'h63;
		if (cp >= 21'hE8 && cp <= 21'hEB) return 21'h65;
		if (cp >= 21'hEC && cp <= 21'hEF) return 21'h69;
		if (cp == 21'hF1) return 21'h6E;
		if (cp >= 21'hF2 && cp <= 21'hF6) return 21'h6F;
		if (cp >= 21'hF9 && cp <= 21'hFC) return 21'h75;
		return cp;
	endfunction

	function automatic fold_t fold_cp(cp_t cp);
		cp_t   s;
		fold_t r;
		s      = strip_accent(cp);
		r.cp   = s;
		r.kind = FK_ONE;
		if (s >= CP_COMB_LO && s <= CP_COMB_HI) begin
			r.kind = FK_DROP;
		end else if (s >= CP_UPPER_A && s <= CP_UPPER_Z) begin
			r.cp = s + CASE_OFS;
		end else if (s == CP_SHARP_S) begin
			r.cp   = CP_LOWER_S;
			r.kind = FK_TWICE;
		end else if (s >= CP_LATX_LO && s <= CP_LATX_HI) begin
			r.cp = s | 21'd1;
		end else if (s >= CP_CYR_LO && s <= CP_CYR_HI) begin
			r.cp = s + CASE_OFS;
		end else if (s == CP_CYR_IO) begin
			r.cp = CP_CYR_IO_L;
		end else if (s == CP_SIGMA_U || s == CP_SIGMA_F) begin
			r.cp = CP_SIGMA_L;
		end else if ((s >= CP_GRK_LO && s <= CP_GRK_MID1) ||
			(s >= CP_GRK_MID2 && s <= CP_GRK_HI)) begin
			r.cp = s + CASE_OFS;
		end
		return r;
	endfunction

	function automatic logic [2:0] utf8_len(cp_t cp);
		if (cp < 21'h80) return 3'd1;
		if (cp < 21'h800) return 3'd2;
		if (cp < 21'h10000) return 3'd3;
		return 3'd4;
	endfunction

	function automatic logic [7:0] utf8_byte(cp_t cp, logic [2:0] len, logic [1:0] k);
		logic [1:0] sh;
		logic [7:0] b;
		sh = 2'(len - 3'd1) - k;
		if (len == 3'd1) begin
			b = cp[7:0];
		end else if (k == 2'd0) begin
			case (len)
				3'd2:    b = {3'b110, cp[10:6]};
				3'd3:    b = {4'b1110, cp[15:12]};
				default: b = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (sh)
				2'd0:    b = {2'b10, cp[5:0]};
				2'd1:    b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[17:12]};
			endcase
		end
		return b;
	endfunction

endpackage

[src/uacf_front.sv]
module uacf_front import uacf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job,
	output front_stat_t stat
);

	logic [7:0] held_q [3];
	logic [1:0] need_q;
	logic [1:0] cnt_q;
	logic [1:0] need;
	logic       accept;
	logic       done;
	logic [7:0] r0;

	always_comb begin
		accept   = in_valid && !q_full;
		need     = (cnt_q != 2'd0) ? need_q : lead_need(in_byte);
		done     = in_last || (cnt_q >= need);
		r0       = held_q[1];
		push_job = '0;
		if (cnt_q == 2'd0) begin
			push_job.cps[0] = single_cp(in_byte);
			push_job.cnt    = 2'd1;
		end else if (cnt_q == need_q) begin
			push_job.cnt = 2'd1;
			case (need_q)
				2'd1:    push_job.cps[0] = {10'd0, held_q[0][4:0], in_byte[5:0]};
				2'd2:    push_job.cps[0] = {5'd0, held_q[0][3:0], held_q[1][5:0],
					in_byte[5:0]};
				2'd3:    push_job.cps[0] = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
					in_byte[5:0]};
				default: push_job.cps[0] = CP_REPL;
			endcase
		end else begin
			// The string ended inside a sequence: the lead is replaced and the
			// bytes after it are decoded again as new leads.
			push_job.cps[0] = CP_REPL;
			if (cnt_q == 2'd1) begin
				push_job.cps[1] = single_cp(in_byte);
				push_job.cnt    = 2'd2;
			end else if (!r0[7]) begin
				push_job.cps[1] = {13'd0, r0};
				push_job.cps[2] = single_cp(in_byte);
				push_job.cnt    = 2'd3;
			end else if (r0[7:5] == 3'b110) begin
				push_job.cps[1] = {10'd0, r0[4:0], in_byte[5:0]};
				push_job.cnt    = 2'd2;
			end else begin
				push_job.cps[1] = CP_REPL;
				push_job.cps[2] = single_cp(in_byte);
				push_job.cnt    = 2'd3;
			end
		end
	end

	assign push          = accept && done;
	assign in_stall      = q_full;
	assign stat.seq_open = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			need_q <= 2'd0;
		end else if (accept) begin
			if (done) begin
				cnt_q  <= 2'd0;
				need_q <= 2'd0;
			end else begin
				cnt_q  <= cnt_q + 2'd1;
				need_q <= need;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !done) begin
			held_q[cnt_q] <= in_byte;
		end
	end

endmodule

[src/uacf_queue.sv]
module uacf_queue import uacf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head_job,
	output logic nempty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign nempty   = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nempty;
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

[src/uacf_back.sv]
module uacf_back import uacf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nempty,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output back_stat_t stat
);

	fold_t      f [3];
	cp_t        c_cp [3];
	logic       c_tw [3];
	logic [1:0] c_num;

	cp_t        w_cp_q [3];
	logic       w_tw_q [3];
	logic [1:0] num_q;
	logic [1:0] slot_q;
	logic [1:0] bidx_q;
	logic       rep_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	cp_t        cur_cp;
	logic [2:0] cur_len;
	logic [7:0] cur_byte;
	logic       cp_end;
	logic       rep_end;
	logic       job_end;
	logic       can_load;
	logic       emit;

	// Fold the head word and pack the code points that survive to the front.
	always_comb begin
		c_num = 2'd0;
		for (int i = 0; i < 3; i++) begin
			f[i]    = fold_cp(head_job.cps[i]);
			c_cp[i] = '0;
			c_tw[i] = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < head_job.cnt && f[i].kind != FK_DROP) begin
				c_cp[c_num] = f[i].cp;
				c_tw[c_num] = (f[i].kind == FK_TWICE);
				c_num       = c_num + 2'd1;
			end
		end
	end

	always_comb begin
		cur_cp   = w_cp_q[slot_q];
		cur_len  = utf8_len(cur_cp);
		cur_byte = utf8_byte(cur_cp, cur_len, bidx_q);
		cp_end   = ({1'b0, bidx_q} == cur_len - 3'd1);
		rep_end  = cp_end && (!w_tw_q[slot_q] || rep_q);
		job_end  = rep_end && (slot_q == num_q - 2'd1);
		can_load = !out_valid_q || !out_stall;
		emit     = busy_q && can_load;
		pop      = q_nempty && (!busy_q || (emit && job_end));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			num_q       <= 2'd0;
			slot_q      <= 2'd0;
			bidx_q      <= 2'd0;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				busy_q <= (c_num != 2'd0);
				num_q  <= c_num;
				slot_q <= 2'd0;
				bidx_q <= 2'd0;
				rep_q  <= 1'b0;
			end else if (emit) begin
				if (job_end) begin
					busy_q <= 1'b0;
				end else if (cp_end) begin
					bidx_q <= 2'd0;
					if (w_tw_q[slot_q] && !rep_q) begin
						rep_q <= 1'b1;
					end else begin
						rep_q  <= 1'b0;
						slot_q <= slot_q + 2'd1;
					end
				end else begin
					bidx_q <= bidx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 3; i++) begin
				w_cp_q[i] <= c_cp[i];
				w_tw_q[i] <= c_tw[i];
			end
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			run_last_q <= job_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign stat.busy = busy_q;
	assign stat.pop  = pop;

endmodule

[src/utf8_accent_case_folder_core.sv]
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_stall  in_byte, in_last
// out      output     out_valid / out_stall out_byte, run_last
//
// One input word is taken per cycle while the four-word queue has room.
// Each input word that closes a sequence yields zero to nine output
// words, sent one per cycle while out_stall is low; the back end's byte serializer sets the rate.
// The first output word passes through the queue, the back end's word registers and the output register.
// Reset clears the open sequence, the queue and the output valid flag.
// in_stall rises only when the queue is full; out_stall holds the output register.
module utf8_accent_case_folder_core import uacf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic        push;
	job_t        push_job;
	logic        q_full;
	logic        q_nempty;
	job_t        head_job;
	logic        pop;
	front_stat_t fstat;
	back_stat_t  bstat;

	uacf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.stat     (fstat)
	);

	uacf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_job (head_job),
		.nempty   (q_nempty)
	);

	uacf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.stat      (bstat)
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> q_nempty)
		else $error("back end popped an empty queue");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_last) |=> !fstat.seq_open)
		else $error("sequence still open after the final word");

	a_ascii_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !fstat.seq_open && !in_byte[7]) |-> push)
		else $error("ASCII word outside a sequence was not queued");
`endif

endmodule

[tb/sv/utf8_accent_case_folder_core_tb.sv]
module utf8_accent_case_folder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_BYTES = 444;
	localparam int TAIL_BYTES   = 60;
	localparam int OPENING_LEN  = 26;
	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

	// Each entry is {last, byte}; the first entry sits in the top bits.
	localparam logic [9*OPENING_LEN-1:0] OPENING = {
		9'h100,
		9'h0C3, 9'h080, 9'h0C3, 9'h09F, 9'h0CC, 9'h181,
		9'h0C4, 9'h080, 9'h0D0, 9'h081, 9'h0CE, 9'h0A3, 9'h0CF, 9'h182,
		9'h180,
		9'h1FF,
		9'h0C3, 9'h141,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
		9'h0F0, 9'h0C3, 9'h1A9
	};

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       drain;
	} in_word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} out_word_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	in_word_t   byte_q[$];
	out_word_t  folded_q[$];
	logic [7:0] step_out[$];
	logic [7:0] str_b[$];

	logic [7:0] seq_bytes [3];
	int         seq_need    = 0;
	int         seq_held    = 0;
	bit         in_fired    = 1'b0;
	bit         tail        = 1'b0;
	int         mismatches  = 0;
	int         src_gap     = 0;
	int         sink_gap    = 0;
	int         idle_cycles = 0;

	utf8_accent_case_folder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] utf8_pack(input logic [20:0] cp, output int n);
		if (cp < 21'h80) begin
			n = 1;
			return {cp[7:0], 24'd0};
		end
		if (cp < 21'h800) begin
			n = 2;
			return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
		end
		if (cp < 21'h10000) begin
			n = 3;
			return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
		end
		n = 4;
		return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
	endfunction

	function automatic void emit_point(input logic [20:0] cp);
		logic [31:0] pk;
		int          n;
		pk = utf8_pack(cp, n);
		for (int k = 0; k < n; k++) begin
			if (step_out.size() < 9)
				step_out.insert(step_out.size(), pk[31-8*k -: 8]);
		end
	endfunction

	// Accented Latin-1 letters of either case end up as the lowercase base letter.
	function automatic logic [7:0] accent_base(input logic [4:0] ofs);
		if (ofs <= 5'd5) return 8'h61;
		if (ofs == 5'd7) return 8'h63;
		if (ofs >= 5'd8 && ofs <= 5'd11) return 8'h65;
		if (ofs >= 5'd12 && ofs <= 5'd15) return 8'h69;
		if (ofs == 5'd17) return 8'h6E;
		if (ofs >= 5'd18 && ofs <= 5'd22) return 8'h6F;
		if (ofs >= 5'd25 && ofs <= 5'd28) return 8'h75;
		return 8'h00;
	endfunction

	function automatic void fold_point(input logic [20:0] cp);
		logic [7:0] base;
		base = (cp >= 21'hC0 && cp <= 21'hFF) ? accent_base(cp[4:0]) : 8'h00;
		if (base != 8'h00) begin
			emit_point({13'd0, base});
		end else if (cp >= 21'h300 && cp <= 21'h36F) begin
		end else if (cp >= 21'h41 && cp <= 21'h5A) begin
			emit_point(cp + 21'd32);
		end else if (cp == 21'hDF) begin
			emit_point(21'h73);
			emit_point(21'h73);
		end else if (cp >= 21'h100 && cp <= 21'h24F) begin
			emit_point(cp | 21'd1);
		end else if (cp >= 21'h410 && cp <= 21'h42F) begin
			emit_point(cp + 21'd32);
		end else if (cp == 21'h401) begin
			emit_point(21'h451);
		end else if (cp == 21'h3A3 || cp == 21'h3C2) begin
			emit_point(21'h3C3);
		end else if ((cp >= 21'h391 && cp <= 21'h3A1) || (cp >= 21'h3A4 && cp <= 21'h3AB)) begin
			emit_point(cp + 21'd32);
		end else begin
			emit_point(cp);
		end
	endfunction

	function automatic void decode_run(input logic [31:0] run_w, input int len);
		int          i;
		int          rem;
		logic [7:0]  c;
		logic [20:0] cp;
		i = 0;
		while (i < len) begin
			c   = run_w[8*i +: 8];
			i   = i + 1;
			rem = len - i;
			if (!c[7]) begin
				cp = {13'd0, c};
			end else if (c[7:5] == 3'b110 && rem >= 1) begin
				cp = {10'd0, c[4:0], run_w[8*i +: 6]};
				i  = i + 1;
			end else if (c[7:4] == 4'b1110 && rem >= 2) begin
				cp = {5'd0, c[3:0], run_w[8*i +: 6], run_w[8*(i+1) +: 6]};
				i  = i + 2;
			end else if (c[7:3] == 5'b11110 && rem >= 3) begin
				cp = {c[2:0], run_w[8*i +: 6], run_w[8*(i+1) +: 6], run_w[8*(i+2) +: 6]};
				i  = i + 3;
			end else begin
				cp = REPLACEMENT;
			end
			fold_point(cp);
		end
	endfunction

	function automatic int lead_length(input logic [7:0] c);
		if (c[7:5] == 3'b110) return 1;
		if (c[7:4] == 4'b1110) return 2;
		if (c[7:3] == 5'b11110) return 3;
		return 0;
	endfunction

	function automatic void fold_byte(input logic [7:0] b, input logic last);
		logic [31:0] run_w;
		int          len;
		int          need;
		out_word_t   ow;
		run_w = '0;
		for (int k = 0; k < seq_held; k++)
			run_w[8*k +: 8] = seq_bytes[k];
		run_w[8*seq_held +: 8] = b;
		len  = seq_held + 1;
		need = (seq_held != 0) ? seq_need : lead_length(b);
		if (last || len - 1 >= need) begin
			step_out.delete();
			decode_run(run_w, len);
			seq_held = 0;
			seq_need = 0;
			for (int k = 0; k < step_out.size(); k++) begin
				ow.b    = step_out[k];
				ow.last = (k == step_out.size() - 1);
				folded_q.insert(folded_q.size(), ow);
			end
		end else begin
			seq_bytes[len-1] = b;
			seq_held         = len;
			seq_need         = need;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [8:0] got,
		input logic [8:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch_words
		out_word_t want;
		bit        out_fired;
		in_fired  = arst_n && in_valid && !in_stall;
		out_fired = arst_n && out_valid && !out_stall;
		tail      = byte_q.size() < TAIL_BYTES;
		if (in_fired)
			fold_byte(in_byte, in_last);
		if (out_fired) begin
			if (folded_q.size() == 0) begin
				report_mismatch("unexpected word", {run_last, out_byte}, 9'h000);
			end else begin
				want = folded_q.pop_front();
				if (out_byte !== want.b)
					report_mismatch("out_byte", {1'b0, out_byte}, {1'b0, want.b});
				if (run_last !== want.last)
					report_mismatch("run_last", {8'd0, run_last}, {8'd0, want.last});
			end
		end
		if (!arst_n || in_fired || out_fired)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// A word flagged for draining is held back until every expected word has come out.
	always @(negedge clk) begin : feed_bytes
		in_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fired) begin
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (byte_q.size() == 0 || (byte_q[0].drain && folded_q.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (!tail && $urandom_range(0, 11) == 0) begin
				src_gap = int'($urandom_range(0, 13));
				in_valid <= 1'b0;
			end else begin
				w = byte_q.pop_front();
				in_byte  <= w.b;
				in_last  <= w.last;
				in_valid <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin : hold_results
		if (!arst_n || tail) begin
			out_stall <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_gap = int'($urandom_range(0, 13));
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : run_strings
		in_word_t    w;
		logic [31:0] pk;
		logic [20:0] cp;
		logic [8:0]  ent;
		int          n;
		int          mode;
		bit          drain;
		bit          first_random;

		for (int k = 0; k < OPENING_LEN; k++) begin
			ent     = OPENING[9*(OPENING_LEN-1-k) +: 9];
			w.b     = ent[7:0];
			w.last  = ent[8];
			w.drain = 1'b0;
			byte_q.insert(byte_q.size(), w);
		end

		first_random = 1'b1;
		while (byte_q.size() < OPENING_LEN + RANDOM_BYTES) begin
			str_b.delete();
			mode = int'($urandom_range(0, 19));
			if (mode == 0) begin
				repeat ($urandom_range(1, 6))
					str_b.insert(str_b.size(), 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 11))
						0: cp = 21'($urandom_range(0, 'h7F));
						1: cp = 21'($urandom_range('h41, 'h5A));
						2: cp = 21'($urandom_range('h80, 'hFF));
						3: cp = 21'h0000DF;
						4: cp = 21'($urandom_range('h300, 'h36F));
						5: cp = 21'($urandom_range('h100, 'h24F));
						6: cp = 21'($urandom_range('h400, 'h45F));
						7: cp = 21'($urandom_range('h380, 'h3CF));
						8: cp = $urandom_range(0, 1) ? 21'h0003A3 : 21'h0003C2;
						9: cp = 21'($urandom_range('h800, 'hFFFF));
						10: cp = 21'($urandom_range('h10000, 'h1FFFFF));
						default: cp = 21'($urandom_range('h80, 'h7FF));
					endcase
					pk = utf8_pack(cp, n);
					for (int k = 0; k < n; k++)
						str_b.insert(str_b.size(), pk[31-8*k -: 8]);
				end
				if (mode == 1) begin
					str_b[$urandom_range(0, str_b.size() - 1)] = 8'($urandom_range(0, 255));
				end else if (mode == 2) begin
					str_b.insert($urandom_range(0, str_b.size() - 1),
						8'h80 | 8'($urandom_range(0, 127)));
				end else if (mode == 3) begin
					repeat ($urandom_range(1, 3)) begin
						if (str_b.size() > 1)
							void'(str_b.pop_back());
					end
				end
			end
			drain = first_random || $urandom_range(0, 14) == 0;
			for (int k = 0; k < str_b.size(); k++) begin
				w.b     = str_b[k];
				w.last  = (k == str_b.size() - 1);
				w.drain = drain && k == 0;
				byte_q.insert(byte_q.size(), w);
			end
			first_random = 1'b0;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || in_valid)
			@(negedge clk);
		while (folded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
src/uacf_pkg.sv
src/uacf_front.sv
src/uacf_queue.sv
src/uacf_back.sv
src/utf8_accent_case_folder_core.sv
tb/sv/utf8_accent_case_folder_core_tb.sv
